FILE: hw/rtl/bcf_pkg.sv
// Shared constants, types and codes of the cascaded biquad filter.
package bcf_pkg;

	localparam int STAGES       = 8;
	localparam int SAMPLE_WIDTH = 16;

	localparam int REG_W     = 64;                 // one packed a1/a2 register
	localparam int CW        = REG_W / 2;          // a1 or a2, Q2.30
	localparam int NUM_CFG   = 8;                  // register file size, fixed
	localparam int CFG_IDX_W = $clog2(NUM_CFG);

	localparam int ACC_W    = 40;                  // Q8.32 section values
	localparam int FRAC_W   = 32;
	localparam int IN_SHIFT = 33 - SAMPLE_WIDTH;   // sample to Q8.32
	localparam int X_W      = ACC_W + 2;           // u + 2*u1 + u2
	localparam int CHUNK_W  = X_W / 2;             // multiplier operand slice
	localparam int COEF_W   = CW + 2;              // 2^30 + a1 + a2
	localparam int PP_W     = COEF_W + CHUNK_W + 1;
	localparam int SUM_W    = 80;                  // exact sum in 2^-64 units
	localparam int FB_SHIFT = 2;                   // feedback terms weigh 4x
	localparam int NUM_PP   = 6;                   // partial products per item
	localparam int STEP_W   = $clog2(NUM_PP);

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic signed [ACC_W-1:0]        acc_t;
	typedef logic signed [X_W-1:0]          xsum_t;
	typedef logic signed [COEF_W-1:0]       coef_t;
	typedef logic signed [PP_W-1:0]         pp_t;
	typedef logic signed [SUM_W-1:0]        wsum_t;
	typedef logic [STEP_W-1:0]              step_t;
	typedef logic [REG_W-1:0]               coeff_reg_t;
	typedef logic [CFG_IDX_W-1:0]           cfg_idx_t;

	localparam step_t LAST_STEP  = step_t'(NUM_PP - 1);
	localparam coef_t ONE_Q30    = coef_t'(2 ** 30);
	localparam wsum_t ROUND_HALF = wsum_t'(64'h0000_0000_8000_0000);
	localparam acc_t  ACC_MAX    = acc_t'({1'b0, {(ACC_W - 1){1'b1}}});
	localparam acc_t  ACC_MIN    = acc_t'({1'b1, {(ACC_W - 1){1'b0}}});
	localparam sample_t SMAX     = sample_t'({1'b0, {(SAMPLE_WIDTH - 1){1'b1}}});
	localparam sample_t SMIN     = sample_t'({1'b1, {(SAMPLE_WIDTH - 1){1'b0}}});

	// Section state machine.
	typedef enum logic [1:0] {
		CS_IDLE,
		CS_MUL,
		CS_ACC,
		CS_RND
	} cell_state_t;

	// Which product a multiply step works on.
	typedef enum logic [1:0] {
		TERM_FWD,
		TERM_FB1,
		TERM_FB2
	} term_t;

	// Item moving from one section to the next.
	typedef struct packed {
		logic valid;
		logic clip;
		acc_t data;
	} cell_link_t;

endpackage

FILE: hw/rtl/bcf_in_if.sv
// Input sample channel.
interface bcf_in_if;
	import bcf_pkg::*;

	logic    valid;
	logic    ready;
	sample_t sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

FILE: hw/rtl/bcf_out_if.sv
// Filtered sample channel.
interface bcf_out_if;
	import bcf_pkg::*;

	logic    valid;
	logic    ready;
	sample_t sample_out;
	logic    clipped;

	modport source (output valid, output sample_out, output clipped, input ready);
	modport sink (input valid, input sample_out, input clipped, output ready);
endinterface

FILE: hw/rtl/bcf_cell.sv
// One second-order section: history, shared multiplier, accumulator, rounding.
module bcf_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  bcf_pkg::coeff_reg_t coeffs,
	input  bcf_pkg::cell_link_t up,
	output logic                up_ready,
	output bcf_pkg::cell_link_t dn,
	input  logic                dn_ready
);
	import bcf_pkg::*;

	cell_state_t state_q, state_d;
	step_t       step_q;
	acc_t        u1_q, u2_q, y1_q, y2_q;
	xsum_t       x_q;
	coef_t       ksum_q;
	pp_t         pp_s1;
	logic        pp_vld_s1, pp_hi_s1, pp_fb_s1;
	wsum_t       acc_q;
	logic        clip_q, clip_out_q, dn_vld_q;

	logic        take_in, issue, retire, out_free;
	coef_t       a1, a2, mul_a;
	xsum_t       mul_src, x_new;
	logic signed [CHUNK_W:0] mul_b;
	term_t       term;
	wsum_t       pp_term, rsum;
	acc_t        y_new;
	logic        y_sat;

	assign a1 = coef_t'($signed(coeffs[REG_W-1:CW]));
	assign a2 = coef_t'($signed(coeffs[CW-1:0]));
	assign out_free = !dn_vld_q || dn_ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CS_IDLE: if (up.valid) state_d = CS_MUL;
			CS_MUL:  if (step_q == LAST_STEP) state_d = CS_ACC;
			CS_ACC:  state_d = CS_RND;
			CS_RND:  if (out_free) state_d = CS_IDLE;
			default: state_d = CS_IDLE;
		endcase
	end

	// Control outputs.
	always_comb begin
		up_ready = 1'b0;
		take_in  = 1'b0;
		issue    = 1'b0;
		retire   = 1'b0;
		unique case (state_q)
			CS_IDLE: begin
				up_ready = 1'b1;
				take_in  = up.valid;
			end
			CS_MUL:  issue  = 1'b1;
			CS_ACC:  ;
			CS_RND:  retire = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (issue) step_q <= (step_q == LAST_STEP) ? '0 : step_q + step_t'(1);
		end
	end

	assign x_new = xsum_t'(up.data) + (xsum_t'(u1_q) <<< 1) + xsum_t'(u2_q);

	// Input history shifts on accept; output history on retire.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			u1_q <= '0;
			u2_q <= '0;
			y1_q <= '0;
			y2_q <= '0;
		end else begin
			if (take_in) begin
				u2_q <= u1_q;
				u1_q <= up.data;
			end
			if (retire) begin
				y2_q <= y1_q;
				y1_q <= y_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			x_q    <= x_new;
			ksum_q <= ONE_Q30 + a1 + a2;
			clip_q <= up.clip;
		end
	end

	// Operand select for the shared multiplier.
	always_comb begin
		term = term_t'(step_q[STEP_W-1:1]);
		case (term)
			TERM_FWD: begin
				mul_a   = ksum_q;
				mul_src = x_q;
			end
			TERM_FB1: begin
				mul_a   = a1;
				mul_src = xsum_t'(y1_q);
			end
			TERM_FB2: begin
				mul_a   = a2;
				mul_src = xsum_t'(y2_q);
			end
			default: begin
				mul_a   = '0;
				mul_src = '0;
			end
		endcase
		if (step_q[0]) mul_b = {mul_src[X_W-1], mul_src[X_W-1:CHUNK_W]};
		else           mul_b = {1'b0, mul_src[CHUNK_W-1:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pp_vld_s1 <= 1'b0;
		else         pp_vld_s1 <= issue;
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			pp_s1    <= mul_a * mul_b;
			pp_hi_s1 <= step_q[0];
			pp_fb_s1 <= (term != TERM_FWD);
		end
	end

	// Align the partial product and fold it in.
	always_comb begin
		pp_term = wsum_t'(pp_s1);
		if (pp_hi_s1) pp_term = pp_term <<< CHUNK_W;
		if (pp_fb_s1) pp_term = pp_term <<< FB_SHIFT;
	end

	always_ff @(posedge clk) begin
		if (take_in)        acc_q <= '0;
		else if (pp_vld_s1) acc_q <= pp_fb_s1 ? acc_q - pp_term : acc_q + pp_term;
	end

	// Round half up to Q8.32, saturate to 40 bits.
	assign rsum  = acc_q + ROUND_HALF;
	assign y_sat = !((&rsum[SUM_W-1:FRAC_W+ACC_W-1]) || !(|rsum[SUM_W-1:FRAC_W+ACC_W-1]));
	assign y_new = y_sat ? (rsum[SUM_W-1] ? ACC_MIN : ACC_MAX)
	                     : rsum[FRAC_W+ACC_W-1:FRAC_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)      dn_vld_q <= 1'b0;
		else if (retire)  dn_vld_q <= 1'b1;
		else if (dn_ready) dn_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (retire) clip_out_q <= clip_q | y_sat;
	end

	// The newest output history entry is the result being handed on.
	assign dn = '{valid: dn_vld_q, clip: clip_out_q, data: y1_q};

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(up.valid && up_ready) |=> (state_q == CS_MUL && step_q == '0))
		else $error("section did not start multiply sequence after accept");

	a_acc_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == CS_ACC) |-> $past(state_q == CS_MUL && step_q == LAST_STEP))
		else $error("accumulate entered before last partial product");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == CS_RND && dn_vld_q && !dn_ready) |=> (state_q == CS_RND && $stable(y1_q)))
		else $error("section result overwritten while downstream stalled");

	a_valid_from_rnd: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(dn_vld_q) |-> $past(state_q == CS_RND))
		else $error("section output valid raised outside rounding step");

endmodule

FILE: hw/rtl/bcf_out_stage.sv
// Output register: round Q8.32 to the sample width and saturate.
module bcf_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  bcf_pkg::cell_link_t up,
	output logic                up_ready,
	bcf_out_if.source           result_ch
);
	import bcf_pkg::*;

	localparam int O_W = ACC_W + 1 - IN_SHIFT;

	logic                     vld_q;
	sample_t                  sample_q;
	logic                     clip_q;
	logic signed [ACC_W:0]    osum;
	logic signed [O_W-1:0]    o;
	logic                     o_sat;
	logic                     take;

	assign up_ready = !vld_q || result_ch.ready;
	assign take     = up.valid && up_ready;

	assign osum  = (ACC_W+1)'(up.data) + (ACC_W+1)'(2 ** (IN_SHIFT - 1));
	assign o     = osum[ACC_W:IN_SHIFT];
	assign o_sat = !((&o[O_W-1:SAMPLE_WIDTH-1]) || !(|o[O_W-1:SAMPLE_WIDTH-1]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)                vld_q <= 1'b0;
		else if (take)              vld_q <= 1'b1;
		else if (result_ch.ready)   vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sample_q <= o_sat ? (o[O_W-1] ? SMIN : SMAX) : o[SAMPLE_WIDTH-1:0];
			clip_q   <= up.clip | o_sat;
		end
	end

	assign result_ch.valid      = vld_q;
	assign result_ch.sample_out = sample_q;
	assign result_ch.clipped    = clip_q;

endmodule

FILE: hw/rtl/biquad_cascade_iir_filter.sv
// Top level: coefficient registers, chain of biquad sections, output register.
//
//   channel     dir  handshake        payload
//   sample_ch   in   valid / ready    sample_in  (signed, SAMPLE_WIDTH)
//   result_ch   out  valid / ready    sample_out (signed, SAMPLE_WIDTH), clipped
//   cfg_*       in   cfg_we           cfg_index, cfg_data (64 bits, write only)
//
// Each section accepts an item, forms six partial products through its single
// 34x22 multiplier, folds in the last product and rounds, waiting in the rounding
// step while its previous result is still unclaimed. Sections overlap, but each
// takes a new item only once it has handed its last result on.
// Reset clears the section histories, the coefficient registers and all valids.
// A stalled result_ch holds the output register; backpressure then climbs the
// chain one section at a time, and no item is dropped.
module biquad_cascade_iir_filter (
	input  logic                clk,
	input  logic                arst_n,
	bcf_in_if.sink              sample_ch,
	bcf_out_if.source           result_ch,
	input  logic                cfg_we,
	input  bcf_pkg::cfg_idx_t   cfg_index,
	input  bcf_pkg::coeff_reg_t cfg_data
);
	import bcf_pkg::*;

	coeff_reg_t coeff_q [STAGES];
	cell_link_t link    [STAGES+1];
	logic       rdy     [STAGES+1];

	// Coefficient registers: one packed a1/a2 word per section.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STAGES; i++) coeff_q[i] <= '0;
		end else if (cfg_we) begin
			for (int i = 0; i < STAGES; i++) begin
				if (cfg_index == cfg_idx_t'(i)) coeff_q[i] <= cfg_data;
			end
		end
	end

	// Bring the sample into Q8.32 and feed the first section.
	assign link[0] = '{
		valid: sample_ch.valid,
		clip:  1'b0,
		data:  acc_t'(sample_ch.sample_in) <<< IN_SHIFT
	};
	assign sample_ch.ready = rdy[0];

	// Sections in series; each hands its result to the next.
	for (genvar s = 0; s < STAGES; s++) begin : g_sec
		bcf_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.coeffs   (coeff_q[s]),
			.up       (link[s]),
			.up_ready (rdy[s]),
			.dn       (link[s+1]),
			.dn_ready (rdy[s+1])
		);
	end

	// Round and saturate the last section's output to the sample width.
	bcf_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.up        (link[STAGES]),
		.up_ready  (rdy[STAGES]),
		.result_ch (result_ch)
	);

endmodule

FILE: bench/tb.sv
// Self-checking testbench for the cascaded biquad filter: predictor, stimulus and checks.
module tb;
	import bcf_pkg::*;

	localparam int     CLK_HALF     = 5;
	localparam int     IDLE_LIMIT   = 20000;            // cycles with no item moving
	localparam int     DRAIN_CYCLES = 9 * STAGES + 20;  // quiet time after the last result
	localparam int     NUM_REGS     = 2 ** CFG_IDX_W;
	localparam int     HIST_DEPTH   = 2 + 2 * STAGES;
	localparam int     PRINT_CAP    = 40;
	localparam longint SEC_MAX      = (longint'(1) <<< (ACC_W - 1)) - 1;
	localparam longint SEC_MIN      = -(longint'(1) <<< (ACC_W - 1));

	typedef logic signed [127:0] wide_t;

	typedef struct {
		sample_t sample;
		logic    clip;
	} filtered_t;

	typedef enum {
		COEF_STABLE,
		COEF_RESONANT,
		COEF_NOISE,
		COEF_EXTREME,
		COEF_ZERO
	} coef_style_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	cfg_idx_t   cfg_index;
	coeff_reg_t cfg_data;

	bcf_in_if  sample_ch ();
	bcf_out_if result_ch ();

	biquad_cascade_iir_filter uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_ch),
		.result_ch (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #CLK_HALF clk = ~clk;

	// Predictor state: coefficient copy and the raw Q8.32 histories.
	coeff_reg_t coeff_model [NUM_REGS];
	coeff_reg_t coeff_plan  [NUM_REGS];
	longint     filter_history [HIST_DEPTH];
	filtered_t  expected_outputs [$];

	// Idling knobs, percent chance per decision; hold request for the receiver.
	int      tx_gap_pct = 0;
	int      rx_stall_pct = 0;
	int      results_hold_req = 0;
	int      mismatch_count = 0;
	int      output_count = 0;
	sample_t last_sample = '0;

	task automatic report_mismatch(input string msg);
		if (mismatch_count < PRINT_CAP)
			$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Mostly zero; when idling, mostly short gaps with a few long ones.
	function automatic int pick_gap(input int pct);
		int r;
		if ($urandom_range(0, 99) >= pct)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 20);
		return $urandom_range(21, 120);
	endfunction

	// One second-order section: k*(u + 2u1 + u2) - a1*y1 - a2*y2, exact in 2^-64
	// units, then rounded half up to Q8.32 and saturated to the 40-bit range.
	function automatic longint biquad_section(input int s, input longint u,
			input longint u1, input longint u2, input longint y1, input longint y2,
			inout logic sat);
		logic signed [CW-1:0] c1, c2;
		longint a1, a2, ksum, xsum;
		wide_t acc;
		c1 = coeff_model[s][REG_W-1:CW];
		c2 = coeff_model[s][CW-1:0];
		a1 = c1;
		a2 = c2;
		ksum = (longint'(1) <<< 30) + a1 + a2;
		xsum = u + 2 * u1 + u2;
		acc = wide_t'(ksum) * wide_t'(xsum) + wide_t'(-4 * a1) * wide_t'(y1)
			+ wide_t'(-4 * a2) * wide_t'(y2);
		acc = (acc + (wide_t'(1) <<< 31)) >>> FRAC_W;
		if (acc > wide_t'(SEC_MAX)) begin
			sat = 1'b1;
			return SEC_MAX;
		end
		if (acc < wide_t'(SEC_MIN)) begin
			sat = 1'b1;
			return SEC_MIN;
		end
		return longint'(acc);
	endfunction

	// Run one sample through the whole cascade and advance the histories.
	function automatic filtered_t filter_sample(input sample_t s);
		filtered_t r;
		logic sat;
		longint u, u1, u2, y, o;
		sat = 1'b0;
		u = longint'(s) <<< IN_SHIFT;
		for (int k = 0; k < STAGES; k++) begin
			u1 = filter_history[2 * k];
			u2 = filter_history[2 * k + 1];
			y = biquad_section(k, u, u1, u2, filter_history[2 * k + 2],
				filter_history[2 * k + 3], sat);
			filter_history[2 * k + 1] = u1;
			filter_history[2 * k] = u;
			u = y;
		end
		filter_history[2 * STAGES + 1] = filter_history[2 * STAGES];
		filter_history[2 * STAGES] = u;
		o = (u + (longint'(1) <<< (IN_SHIFT - 1))) >>> IN_SHIFT;
		if (o > longint'(SMAX)) begin
			o = longint'(SMAX);
			sat = 1'b1;
		end
		if (o < longint'(SMIN)) begin
			o = longint'(SMIN);
			sat = 1'b1;
		end
		r.sample = sample_t'(o);
		r.clip = sat;
		return r;
	endfunction

	// Offer one item; valid stays high across back-to-back items.
	task automatic send_sample(input sample_t s);
		int gap;
		gap = pick_gap(tx_gap_pct);
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.sample_in <= s;
		do @(posedge clk); while (!sample_ch.ready);
		expected_outputs.push_back(filter_sample(s));
	endtask

	// Drop valid and hold until every expected result is back.
	task automatic wait_for_drain();
		sample_ch.valid <= 1'b0;
		while (expected_outputs.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Write the whole plan; only called with the filter idle.
	task automatic load_coeff_plan();
		wait_for_drain();
		for (int i = 0; i < NUM_REGS; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= cfg_idx_t'(i);
			cfg_data <= coeff_plan[i];
			@(posedge clk);
			coeff_model[i] = coeff_plan[i];
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [CW-1:0] extreme_word();
		case ($urandom_range(0, 5))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4: return 32'h4000_0000;
			default: return 32'hC000_0000;
		endcase
	endfunction

	// Poles at radius r and angle th: a1 = -2 r cos(th), a2 = r^2, in Q2.30.
	function automatic coeff_reg_t pole_pair(input real r_lo, input real r_span);
		real r, th;
		int q1, q2;
		r = r_lo + r_span * $urandom_range(0, 1000) / 1000.0;
		th = 3.14159265 * $urandom_range(1, 999) / 2000.0;
		q1 = $rtoi(-2.0 * r * $cos(th) * 1073741824.0);
		q2 = $rtoi(r * r * 1073741824.0);
		return {q1[CW-1:0], q2[CW-1:0]};
	endfunction

	function automatic void plan_coeffs(input coef_style_t style);
		for (int i = 0; i < NUM_REGS; i++) begin
			case (style)
				COEF_STABLE:   coeff_plan[i] = pole_pair(0.2, 0.78);
				COEF_RESONANT: coeff_plan[i] = pole_pair(0.95, 0.045);
				COEF_NOISE:    coeff_plan[i] = {$urandom, $urandom};
				COEF_EXTREME:  coeff_plan[i] = {extreme_word(), extreme_word()};
				default:       coeff_plan[i] = '0;
			endcase
		end
	endfunction

	// Random content: full range, small, extremes, or a held value for DC.
	function automatic sample_t random_sample();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			last_sample = sample_t'($urandom);
		else if (r < 70)
			last_sample = sample_t'(int'($urandom_range(0, 511)) - 256);
		else if (r < 80) begin
			case ($urandom_range(0, 3))
				0: last_sample = SMAX;
				1: last_sample = SMIN;
				2: last_sample = '0;
				default: last_sample = '1;
			endcase
		end
		return last_sample;
	endfunction

	// Reset coefficients are zero: every section is the plain 1,2,1 average.
	task automatic test_reset_coeffs();
		sample_t pattern [12];
		pattern = '{16'sh0000, SMAX, SMAX, SMIN, SMIN, 16'sh0001, 16'shFFFF,
			16'sh5555, 16'shAAAA, SMAX, 16'sh0000, SMIN};
		tx_gap_pct = 0;
		rx_stall_pct = 0;
		foreach (pattern[i])
			send_sample(pattern[i]);
		wait_for_drain();
	endtask

	// Coefficient extremes drive the sections and the output into saturation.
	task automatic test_saturation();
		coeff_plan[0] = {32'h8000_0000, 32'h0000_0000};
		coeff_plan[1] = {32'h7FFF_FFFF, 32'h7FFF_FFFF};
		coeff_plan[2] = {32'hFFFF_FFFF, 32'hFFFF_FFFF};
		coeff_plan[3] = {32'h8000_0000, 32'h8000_0000};
		coeff_plan[4] = {32'h7FFF_FFFF, 32'h8000_0000};
		coeff_plan[5] = {32'h0000_0000, 32'h7FFF_FFFF};
		coeff_plan[6] = {32'h8000_0000, 32'h7FFF_FFFF};
		coeff_plan[7] = {32'h0000_0000, 32'h0000_0000};
		load_coeff_plan();
		for (int i = 0; i < 10; i++)
			send_sample(i[0] ? SMIN : SMAX);
		wait_for_drain();
	endtask

	// Phases of random samples, each under its own coefficient set and idling.
	task automatic test_random_phases();
		coef_style_t styles [8];
		styles = '{COEF_STABLE, COEF_STABLE, COEF_NOISE, COEF_STABLE, COEF_RESONANT,
			COEF_EXTREME, COEF_STABLE, COEF_ZERO};
		foreach (styles[p]) begin
			plan_coeffs(styles[p]);
			load_coeff_plan();
			// one phase runs flat out on both sides
			tx_gap_pct = (p == 1) ? 0 : $urandom_range(10, 40);
			rx_stall_pct = (p == 1) ? 0 : $urandom_range(5, 25);
			repeat (90)
				send_sample(random_sample());
		end
		wait_for_drain();
	endtask

	// Hold the receiver off long enough that the chain fills and stalls input.
	task automatic test_output_backpressure();
		plan_coeffs(COEF_STABLE);
		load_coeff_plan();
		tx_gap_pct = 0;
		rx_stall_pct = 0;
		results_hold_req = 600;
		repeat (50)
			send_sample(random_sample());
		wait_for_drain();
	endtask

	// Sender stops mid-stream until every expected result is in, then resumes.
	task automatic test_pause_until_drained();
		tx_gap_pct = 20;
		rx_stall_pct = 15;
		repeat (20)
			send_sample(random_sample());
		wait_for_drain();
		repeat (20)
			send_sample(random_sample());
	endtask

	// Compare each accepted result with the oldest expectation.
	task automatic check_output();
		filtered_t want;
		output_count++;
		if (expected_outputs.size() == 0) begin
			report_mismatch($sformatf("output %0d: unexpected sample %0d clipped %0b",
				output_count, result_ch.sample_out, result_ch.clipped));
		end else begin
			want = expected_outputs.pop_front();
			if (result_ch.sample_out !== want.sample)
				report_mismatch($sformatf("output %0d: sample_out %0d, want %0d",
					output_count, result_ch.sample_out, want.sample));
			if (result_ch.clipped !== want.clip)
				report_mismatch($sformatf("output %0d: clipped %0b, want %0b",
					output_count, result_ch.clipped, want.clip));
		end
	endtask

	// Receiver: check on the edge, then pick ready for the next cycle.
	initial begin
		int stall_left;
		stall_left = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready)
				check_output();
			if (results_hold_req > 0) begin
				stall_left = results_hold_req;
				results_hold_req = 0;
			end
			if (stall_left == 0)
				stall_left = pick_gap(rx_stall_pct);
			if (stall_left > 0) begin
				result_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run if no item moves on either channel for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("biquad_cascade_iir_filter verification failed");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		sample_ch.valid <= 1'b0;
		sample_ch.sample_in <= '0;
		foreach (coeff_model[i])
			coeff_model[i] = '0;
		foreach (filter_history[i])
			filter_history[i] = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_coeffs();
		test_saturation();
		test_random_phases();
		test_output_backpressure();
		test_pause_until_drained();

		// Let any stray result show up before the verdict.
		sample_ch.valid <= 1'b0;
		while (expected_outputs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("biquad_cascade_iir_filter verification clean");
		else
			$display("biquad_cascade_iir_filter verification failed");
		$finish;
	end

endmodule
